### rtl/smpe_pkg.sv
// Shared types and constants of the serial mouse packet encoder.
`default_nettype none

package smpe_pkg;

    // Field widths of the input and result transactions.
    localparam int MOTION_W = 16;
    localparam int WHEEL_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int GAIN_W   = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_PROTOCOL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_BUTTONS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_ENABLE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_GAIN           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_GAIN           = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    // Serial mouse protocols.
    typedef enum logic [1:0] {
        PROTO_TWO   = 2'd0,
        PROTO_WHEEL = 2'd1,
        PROTO_THREE = 2'd2,
        PROTO_FIVE  = 2'd3
    } t_proto;

    // Item kinds.
    localparam logic KIND_REPORT   = 1'b0;
    localparam logic KIND_IDENTIFY = 1'b1;

    // Identification characters.
    localparam logic [BYTE_W-1:0] ID_BASE  = 8'h4D;  // 'M'
    localparam logic [BYTE_W-1:0] ID_THREE = 8'h33;  // '3'
    localparam logic [BYTE_W-1:0] ID_WHEEL = 8'h5A;  // 'Z'

    // Packet framing bits.
    localparam logic [BYTE_W-1:0] SYNC_7BIT   = 8'h40;
    localparam logic [BYTE_W-1:0] SYNC_8BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] LOW6_MASK   = 8'h3F;
    localparam logic [BYTE_W-1:0] WHEEL_MASK  = 8'h0F;
    localparam logic [BYTE_W-1:0] WHEEL_MID   = 8'h10;
    localparam logic [BYTE_W-1:0] RIGHT_BIT   = 8'h10;
    localparam logic [BYTE_W-1:0] LEFT_BIT    = 8'h20;
    localparam logic [BYTE_W-1:0] THREE_MID   = 8'h20;

    // Saturation limits.
    localparam logic [6:0]        MOTION_LIMIT = 7'd127;
    localparam logic [WHEEL_W-1:0] WHEEL_LIMIT = 8'd15;

    localparam int MAX_BYTES = 5;
    localparam int COUNT_W   = 3;

endpackage

`default_nettype wire

### rtl/smpe_in_if.sv
// Input channel of the serial mouse packet encoder: reports and identify requests.
`default_nettype none

interface smpe_in_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic signed [smpe_pkg::MOTION_W-1:0] dx;
    logic signed [smpe_pkg::MOTION_W-1:0] dy;
    logic signed [smpe_pkg::MOTION_W-1:0] dx_late;
    logic signed [smpe_pkg::MOTION_W-1:0] dy_late;
    logic signed [smpe_pkg::WHEEL_W-1:0]  wheel_delta;
    logic                               left_down;
    logic                               middle_down;
    logic                               right_down;
    logic                               revert_protocol;

    modport source (
        output valid, kind, dx, dy, dx_late, dy_late, wheel_delta,
               left_down, middle_down, right_down, revert_protocol,
        input  ready
    );

    modport sink (
        input  valid, kind, dx, dy, dx_late, dy_late, wheel_delta,
               left_down, middle_down, right_down, revert_protocol,
        output ready
    );
endinterface

`default_nettype wire

### rtl/smpe_out_if.sv
// Output channel of the serial mouse packet encoder: one serial byte per transaction.
`default_nettype none

interface smpe_out_if;
    logic                           valid;
    logic                           ready;
    logic [smpe_pkg::BYTE_W-1:0]    tx_byte;
    logic                           last;
    logic                           eight_bit_frame;

    modport source (
        output valid, tx_byte, last, eight_bit_frame,
        input  ready
    );

    modport sink (
        input  valid, tx_byte, last, eight_bit_frame,
        output ready
    );
endinterface

`default_nettype wire

### rtl/serial_mouse_packet_encoder.sv
// Serial mouse packet encoder top level: a three-stage pipeline ending in a byte serializer.
`default_nettype none

// Each input transaction is a movement report or an identify request. A report
// is turned into one serial mouse packet in the active protocol (3 bytes for
// two-button, 4 for wheel, 3 or 4 for three-button, 5 for the 8N1 protocol),
// and only when a button relevant to the protocol changed, motion is nonzero,
// or in wheel mode the wheel moved. An identify request picks the protocol from
// the held buttons and sends its ID bytes ('M', 'M3' or 'MZ'; nothing for the
// five-byte protocol). Motion optionally goes through an unsigned fixed-point
// gain with GAIN_FRACTION_BITS fraction bits, rounded away from zero, and is
// then clamped to +-127; the wheel is clamped to +-15. The pipeline has an
// input register (button decode, protocol and button state update, gain
// multipliers), a packet stage (rounding, clamping, byte assembly) and a packet
// register that is shifted out one byte per output transaction. The first byte
// is presented once its item has passed the input register and the packet stage
// and has been loaded into the packet register. Throughput is set by the output
// serializer: an item holds it until all of its bytes (one to five) are taken,
// and an item that produces no bytes passes without using it. Input transactions
// keep being accepted while a packet is still being shifted out, until all three
// stages hold work and the packet stage item has bytes to send. Configuration
// registers are written through i_cfg_we, i_cfg_index and i_cfg_data and are meant to
// change only while the pipeline is empty.
module serial_mouse_packet_encoder #(
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [smpe_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [smpe_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    smpe_in_if.sink                                    i_in,
    smpe_out_if.source                                 o_out
);

    localparam int MW = smpe_pkg::MOTION_W;
    localparam int PW = smpe_pkg::MOTION_W + smpe_pkg::GAIN_W;
    localparam int BW = smpe_pkg::BYTE_W;
    localparam int CW = smpe_pkg::COUNT_W;

    // Adding this before the shift rounds the magnitude up.
    localparam logic [PW:0] ROUND_ADD = (33'd1 << GAIN_FRACTION_BITS) - 33'd1;
    // Gain of exactly one, used when the gain is switched off.
    localparam logic [smpe_pkg::GAIN_W-1:0] UNITY_GAIN = 16'(1 << GAIN_FRACTION_BITS);

    // Contents of the packet stage.
    typedef struct packed {
        logic                       kind;
        smpe_pkg::t_proto           proto;
        logic                       update;
        logic                       mid_changed;
        logic                       left;
        logic                       middle;
        logic                       right;
        logic signed [smpe_pkg::WHEEL_W-1:0] wheel;
        logic [3:0]                 neg;      // x, y, x late, y late
        logic [PW-1:0]              prod_x;
        logic [PW-1:0]              prod_y;
        logic [PW-1:0]              prod_xl;
        logic [PW-1:0]              prod_yl;
    } t_s2_stage;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    smpe_pkg::t_proto               r_default_protocol;
    logic                           r_swap_buttons;
    logic                           r_gain_enable;
    logic [smpe_pkg::GAIN_W-1:0]    r_x_gain;
    logic [smpe_pkg::GAIN_W-1:0]    r_y_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_protocol <= smpe_pkg::PROTO_TWO;
            r_swap_buttons     <= 1'b0;
            r_gain_enable      <= 1'b0;
            r_x_gain           <= smpe_pkg::GAIN_RESET;
            r_y_gain           <= smpe_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smpe_pkg::CFG_DEFAULT_PROTOCOL: begin
                    r_default_protocol <= smpe_pkg::t_proto'(i_cfg_data[1:0]);
                end
                smpe_pkg::CFG_SWAP_BUTTONS: begin
                    r_swap_buttons <= i_cfg_data[0];
                end
                smpe_pkg::CFG_GAIN_ENABLE: begin
                    r_gain_enable <= i_cfg_data[0];
                end
                smpe_pkg::CFG_X_GAIN: begin
                    r_x_gain <= i_cfg_data;
                end
                smpe_pkg::CFG_Y_GAIN: begin
                    r_y_gain <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake between the stages.
    // ------------------------------------------------------------------
    logic                   r_s1_valid;
    logic                   r_s2_valid;
    logic                   r_s3_valid;
    logic [CW-1:0]          r_s3_left;
    logic                   s3_free;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   s1_go;
    logic                   s3_load;
    logic [CW-1:0]          n_pkt_count;

    // The packet register empties when its final byte is taken.
    assign s3_free  = !r_s3_valid || (o_out.ready && (r_s3_left == CW'(1)));
    // A packet stage item with no bytes leaves without using the packet register.
    assign s2_ready = !r_s2_valid || s3_free || (n_pkt_count == '0);
    assign s3_load  = r_s2_valid && s3_free && (n_pkt_count != '0);
    assign s1_ready = !r_s1_valid || s2_ready;
    assign s1_go    = r_s1_valid && s2_ready;
    assign i_in.ready = s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    logic                               r_s1_kind;
    logic signed [MW-1:0]               r_s1_dx;
    logic signed [MW-1:0]               r_s1_dy;
    logic signed [MW-1:0]               r_s1_dx_late;
    logic signed [MW-1:0]               r_s1_dy_late;
    logic signed [smpe_pkg::WHEEL_W-1:0] r_s1_wheel;
    logic                               r_s1_left;
    logic                               r_s1_middle;
    logic                               r_s1_right;
    logic                               r_s1_revert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1_kind    <= i_in.kind;
            r_s1_dx      <= i_in.dx;
            r_s1_dy      <= i_in.dy;
            r_s1_dx_late <= i_in.dx_late;
            r_s1_dy_late <= i_in.dy_late;
            r_s1_wheel   <= i_in.wheel_delta;
            r_s1_left    <= i_in.left_down;
            r_s1_middle  <= i_in.middle_down;
            r_s1_right   <= i_in.right_down;
            r_s1_revert  <= i_in.revert_protocol;
        end
    end

    // Button decode, protocol selection and the update decision.
    smpe_pkg::t_proto       r_active_protocol;
    logic [2:0]             r_prev_buttons;   // right, middle, left
    smpe_pkg::t_proto       n_active_protocol;
    logic                   s1_left;
    logic                   s1_right;
    logic [2:0]             s1_buttons;
    logic [2:0]             s1_changed;
    logic                   s1_update;
    logic [smpe_pkg::GAIN_W-1:0] s1_gain_x;
    logic [smpe_pkg::GAIN_W-1:0] s1_gain_y;
    t_s2_stage              n_s2;
    t_s2_stage              r_s2;

    function automatic logic [MW-1:0] f_magnitude(input logic signed [MW-1:0] v);
        // The magnitude of the most negative value still fits unsigned.
        f_magnitude = v[MW-1] ? MW'(~v + MW'(1)) : MW'(v);
    endfunction

    assign s1_left    = r_swap_buttons ? r_s1_right : r_s1_left;
    assign s1_right   = r_swap_buttons ? r_s1_left  : r_s1_right;
    assign s1_buttons = {s1_right, r_s1_middle, s1_left};
    assign s1_changed = s1_buttons ^ r_prev_buttons;
    assign s1_gain_x  = r_gain_enable ? r_x_gain : UNITY_GAIN;
    assign s1_gain_y  = r_gain_enable ? r_y_gain : UNITY_GAIN;

    always_comb begin
        // Both outer buttons select three-button mode, then middle, right, left.
        n_active_protocol = r_active_protocol;
        if (s1_right && s1_left) begin
            n_active_protocol = smpe_pkg::PROTO_THREE;
        end else if (r_s1_middle) begin
            n_active_protocol = smpe_pkg::PROTO_WHEEL;
        end else if (s1_right) begin
            n_active_protocol = smpe_pkg::PROTO_TWO;
        end else if (s1_left) begin
            n_active_protocol = smpe_pkg::PROTO_FIVE;
        end else if (r_s1_revert) begin
            n_active_protocol = r_default_protocol;
        end
    end

    // Middle changes only matter where the protocol reports the middle button;
    // wheel motion only matters in wheel mode.
    assign s1_update = s1_changed[0] || s1_changed[2] ||
                       (s1_changed[1] && (r_active_protocol != smpe_pkg::PROTO_TWO)) ||
                       (r_s1_dx != '0) || (r_s1_dy != '0) ||
                       ((r_active_protocol == smpe_pkg::PROTO_WHEEL) && (r_s1_wheel != '0));

    always_comb begin
        n_s2.kind        = r_s1_kind;
        n_s2.proto       = (r_s1_kind == smpe_pkg::KIND_IDENTIFY) ? n_active_protocol
                                                                   : r_active_protocol;
        n_s2.update      = s1_update;
        n_s2.mid_changed = s1_changed[1];
        n_s2.left        = s1_left;
        n_s2.middle      = r_s1_middle;
        n_s2.right       = s1_right;
        n_s2.wheel       = r_s1_wheel;
        n_s2.neg         = {r_s1_dy_late[MW-1], r_s1_dx_late[MW-1],
                            r_s1_dy[MW-1], r_s1_dx[MW-1]};
        n_s2.prod_x      = PW'(f_magnitude(r_s1_dx)) * PW'(s1_gain_x);
        n_s2.prod_y      = PW'(f_magnitude(r_s1_dy)) * PW'(s1_gain_y);
        n_s2.prod_xl     = PW'(f_magnitude(r_s1_dx_late)) * PW'(s1_gain_x);
        n_s2.prod_yl     = PW'(f_magnitude(r_s1_dy_late)) * PW'(s1_gain_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_protocol <= smpe_pkg::PROTO_TWO;
            r_prev_buttons    <= 3'b000;
        end else if (s1_go) begin
            if (r_s1_kind == smpe_pkg::KIND_IDENTIFY) begin
                r_active_protocol <= n_active_protocol;
            end else begin
                r_prev_buttons <= s1_buttons;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rounding, clamping and byte assembly.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= s1_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2 <= n_s2;
        end
    end

    function automatic logic [BW-1:0] f_scale(input logic [PW-1:0] prod, input logic neg);
        logic [PW:0] sum;
        logic [PW:0] quo;
        logic [6:0]  mag;
        begin
            sum = {1'b0, prod} + ROUND_ADD;
            quo = sum >> GAIN_FRACTION_BITS;
            mag = (quo > (PW+1)'(smpe_pkg::MOTION_LIMIT)) ? smpe_pkg::MOTION_LIMIT : quo[6:0];
            f_scale = neg ? BW'(8'd0 - {1'b0, mag}) : {1'b0, mag};
        end
    endfunction

    logic [BW-1:0]          s2_x;
    logic [BW-1:0]          s2_y;
    logic [BW-1:0]          s2_xl;
    logic [BW-1:0]          s2_yl;
    logic signed [BW-1:0]   s2_wheel_sat;
    logic [BW-1:0]          s2_b3;
    logic [BW-1:0]          n_pkt_bytes [smpe_pkg::MAX_BYTES];
    logic                   n_pkt_eight;

    assign s2_x  = f_scale(r_s2.prod_x,  r_s2.neg[0]);
    assign s2_y  = f_scale(r_s2.prod_y,  r_s2.neg[1]);
    assign s2_xl = f_scale(r_s2.prod_xl, r_s2.neg[2]);
    assign s2_yl = f_scale(r_s2.prod_yl, r_s2.neg[3]);

    always_comb begin
        if (r_s2.wheel > $signed(smpe_pkg::WHEEL_LIMIT)) begin
            s2_wheel_sat = $signed(smpe_pkg::WHEEL_LIMIT);
        end else if (r_s2.wheel < -$signed(smpe_pkg::WHEEL_LIMIT)) begin
            s2_wheel_sat = -$signed(smpe_pkg::WHEEL_LIMIT);
        end else begin
            s2_wheel_sat = r_s2.wheel;
        end
    end

    // The wheel byte carries the negated wheel count in its low nibble.
    assign s2_b3 = (BW'(8'd0 - s2_wheel_sat) & smpe_pkg::WHEEL_MASK) |
                   (r_s2.middle ? smpe_pkg::WHEEL_MID : 8'h00);

    always_comb begin
        for (int i = 0; i < smpe_pkg::MAX_BYTES; i++) begin
            n_pkt_bytes[i] = '0;
        end
        n_pkt_count = '0;
        n_pkt_eight = 1'b0;
        if (r_s2.kind == smpe_pkg::KIND_IDENTIFY) begin
            if (r_s2.proto != smpe_pkg::PROTO_FIVE) begin
                n_pkt_bytes[0] = smpe_pkg::ID_BASE;
                n_pkt_count    = CW'(1);
                if (r_s2.proto == smpe_pkg::PROTO_THREE) begin
                    n_pkt_bytes[1] = smpe_pkg::ID_THREE;
                    n_pkt_count    = CW'(2);
                end else if (r_s2.proto == smpe_pkg::PROTO_WHEEL) begin
                    n_pkt_bytes[1] = smpe_pkg::ID_WHEEL;
                    n_pkt_count    = CW'(2);
                end
            end
        end else if (r_s2.update) begin
            if (r_s2.proto == smpe_pkg::PROTO_FIVE) begin
                // Buttons are active low in the sync byte; y goes up.
                n_pkt_bytes[0] = smpe_pkg::SYNC_8BIT |
                                 {5'b00000, !r_s2.left, !r_s2.middle, !r_s2.right};
                n_pkt_bytes[1] = s2_x;
                n_pkt_bytes[2] = BW'(8'd0 - s2_y);
                n_pkt_bytes[3] = s2_xl;
                n_pkt_bytes[4] = BW'(8'd0 - s2_yl);
                n_pkt_count    = CW'(5);
                n_pkt_eight    = 1'b1;
            end else begin
                n_pkt_bytes[0] = smpe_pkg::SYNC_7BIT |
                                 {4'b0000, s2_y[7:6], s2_x[7:6]} |
                                 (r_s2.right ? smpe_pkg::RIGHT_BIT : 8'h00) |
                                 (r_s2.left  ? smpe_pkg::LEFT_BIT  : 8'h00);
                n_pkt_bytes[1] = s2_x & smpe_pkg::LOW6_MASK;
                n_pkt_bytes[2] = s2_y & smpe_pkg::LOW6_MASK;
                n_pkt_count    = CW'(3);
                if (r_s2.proto == smpe_pkg::PROTO_WHEEL) begin
                    n_pkt_bytes[3] = s2_b3;
                    n_pkt_count    = CW'(4);
                end else if ((r_s2.proto == smpe_pkg::PROTO_THREE) &&
                             (r_s2.middle || r_s2.mid_changed)) begin
                    // The fourth byte goes out while middle is held or on its release.
                    n_pkt_bytes[3] = r_s2.middle ? smpe_pkg::THREE_MID : 8'h00;
                    n_pkt_count    = CW'(4);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: packet register, shifted out one byte per transaction.
    // ------------------------------------------------------------------
    logic [BW-1:0]          r_s3_bytes [smpe_pkg::MAX_BYTES];
    logic                   r_s3_eight;
    logic                   out_go;

    assign out_go = r_s3_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s3_left  <= '0;
        end else if (s3_load) begin
            r_s3_valid <= 1'b1;
            r_s3_left  <= n_pkt_count;
        end else if (out_go) begin
            r_s3_valid <= (r_s3_left != CW'(1));
            r_s3_left  <= r_s3_left - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_s3_bytes <= n_pkt_bytes;
            r_s3_eight <= n_pkt_eight;
        end else if (out_go) begin
            for (int i = 0; i < smpe_pkg::MAX_BYTES - 1; i++) begin
                r_s3_bytes[i] <= r_s3_bytes[i+1];
            end
            r_s3_bytes[smpe_pkg::MAX_BYTES-1] <= '0;
        end
    end

    assign o_out.valid           = r_s3_valid;
    assign o_out.tx_byte         = r_s3_bytes[0];
    assign o_out.last            = (r_s3_left == CW'(1));
    assign o_out.eight_bit_frame = r_s3_eight;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the serial mouse packet encoder.

module testbench;
    import smpe_pkg::*;

    // The block is built with the default gain format: eight fraction bits.
    localparam int GAIN_FRACTION_BITS = 8;
    localparam int CLOCK_HALF         = 4;
    // A report that sends nothing still passes the input register and the packet stage;
    // SETTLE_CYCLES quiet cycles are enough for it to clear.
    localparam int SETTLE_CYCLES      = 12;
    localparam int LONG_HOLD          = 120;
    localparam int RANDOM_PER_PHASE   = 34;
    localparam int PHASES             = 4;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int PACKET_W           = MAX_BYTES * BYTE_W;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // One input transaction. Motion fields are kept as raw two's complement bits.
    typedef struct packed {
        logic        kind;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dx_late;
        logic [15:0] dy_late;
        logic [7:0]  wheel;
        logic        left;
        logic        middle;
        logic        right;
        logic        revert;
    } mouse_item_t;

    // One output transaction as the encoder should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eight;
    } serial_byte_t;

    // A row of the directed table. When typed is set, the packet bytes below are the
    // expected result (first byte in the top bits); otherwise the predictor decides.
    typedef struct packed {
        logic        kind;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dx_late;
        logic [15:0] dy_late;
        logic [7:0]  wheel;
        logic        left;
        logic        middle;
        logic        right;
        logic        revert;
        logic        typed;
        logic [2:0]  n_bytes;
        logic [39:0] bytes;
        logic        frame8;
    } stimulus_row_t;

    // The directed part runs with the reset settings: two-button protocol, no swap,
    // no gain. Rows walk through the extremes of motion, the wheel clamp, the
    // middle button being ignored in two-button mode, every identify priority, the
    // three-button fourth byte, the silent five-byte identify and the late motion
    // that never triggers a report by itself.
    localparam stimulus_row_t DIRECTED_TABLE [23] = '{
        '{KIND_IDENTIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0,
          TYPED, 3'd1, 40'h4D_00_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0,
          TYPED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0,
          TYPED, 3'd3, 40'h49_3F_01_00_00, 1'b0},
        '{KIND_REPORT, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0,
          TYPED, 3'd3, 40'h66_01_3F_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0,
          TYPED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_IDENTIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0,
          TYPED, 3'd2, 40'h4D_5A_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h7F, 1'b1, 1'b1, 1'b0, 1'b0,
          TYPED, 3'd4, 40'h60_00_00_11_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h80, 1'b1, 1'b1, 1'b0, 1'b0,
          TYPED, 3'd4, 40'h60_00_00_1F_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0,
          TYPED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_IDENTIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0,
          TYPED, 3'd2, 40'h4D_33_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0,
          PREDICTED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0,
          PREDICTED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0,
          PREDICTED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_IDENTIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0,
          TYPED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0001, 16'h0001, 16'h8000, 16'h7FFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0,
          TYPED, 3'd5, 40'h87_01_FF_81_81, 1'b1},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
          TYPED, 3'd5, 40'h80_00_00_00_00, 1'b1},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h1234, 16'h8000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
          TYPED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_IDENTIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
          TYPED, 3'd1, 40'h4D_00_00_00_00, 1'b0},
        '{KIND_IDENTIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
          TYPED, 3'd1, 40'h4D_00_00_00_00, 1'b0},
        '{KIND_REPORT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
          TYPED, 3'd3, 40'h73_3F_00_00_00, 1'b0},
        '{KIND_IDENTIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
          TYPED, 3'd2, 40'h4D_33_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
          TYPED, 3'd0, 40'h00_00_00_00_00, 1'b0},
        '{KIND_REPORT, 16'h0000, 16'hFF38, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
          PREDICTED, 3'd0, 40'h00_00_00_00_00, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    smpe_in_if  mouse_in ();
    smpe_out_if serial_out ();

    // Testbench copy of the configuration registers.
    t_proto      default_proto;
    logic        swap_on;
    logic        gain_on;
    logic [15:0] x_gain;
    logic [15:0] y_gain;

    // Testbench copy of the encoder state.
    t_proto      active_proto;
    logic [2:0]  prev_buttons;   // bit 0 left, bit 1 middle, bit 2 right, after the swap

    // Bytes the encoder still owes, oldest first.
    serial_byte_t pending_bytes [$];

    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         stall_requests = 0;
    logic [2:0] held_buttons = 3'b000;   // raw {right, middle, left} of the last random report

    serial_mouse_packet_encoder #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (mouse_in),
        .o_out      (serial_out)
    );

    always begin
        #CLOCK_HALF clk = 1'b1;
        #CLOCK_HALF clk = 1'b0;
    end

    // Applies the gain when it is enabled, rounding the magnitude up, restores the
    // sign and clamps to the motion limit. The result is the byte's two's complement.
    function automatic logic [7:0] scale_clip(input logic [15:0] v, input logic [15:0] g);
        logic [16:0] mag;
        logic [63:0] prod;
        mag  = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
        prod = 64'(mag);
        if (gain_on) begin
            prod = (prod * g + ((64'd1 << GAIN_FRACTION_BITS) - 64'd1)) >> GAIN_FRACTION_BITS;
        end
        if (prod > 64'(MOTION_LIMIT)) begin
            prod = 64'(MOTION_LIMIT);
        end
        return v[15] ? 8'(8'd0 - prod[7:0]) : prod[7:0];
    endfunction

    // Works out the bytes one accepted transaction causes and updates the state copy.
    // Returns the byte count; the packet holds the first byte in its top bits.
    function automatic int encode_item(input mouse_item_t it, output logic [PACKET_W-1:0] pkt,
                                       output logic frame8);
        logic        l;
        logic        m;
        logic        r;
        logic [2:0]  btn;
        logic [2:0]  chg;
        t_proto      nxt;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  xl;
        logic [7:0]  yl;
        logic [7:0]  b0;
        logic [7:0]  b3;
        logic [7:0]  w;
        logic        send;
        int          n;
        pkt    = '0;
        frame8 = 1'b0;
        n      = 0;
        l      = swap_on ? it.right : it.left;
        r      = swap_on ? it.left : it.right;
        m      = it.middle;
        btn    = {r, m, l};
        if (it.kind == KIND_IDENTIFY) begin
            // Both outer buttons win over middle, middle over right, right over left.
            nxt = active_proto;
            if (r && l) begin
                nxt = PROTO_THREE;
            end else if (m) begin
                nxt = PROTO_WHEEL;
            end else if (r) begin
                nxt = PROTO_TWO;
            end else if (l) begin
                nxt = PROTO_FIVE;
            end else if (it.revert) begin
                nxt = default_proto;
            end
            active_proto = nxt;
            case (nxt)
                PROTO_TWO: begin
                    pkt = {ID_BASE, 32'h0};
                    n   = 1;
                end
                PROTO_WHEEL: begin
                    pkt = {ID_BASE, ID_WHEEL, 24'h0};
                    n   = 2;
                end
                PROTO_THREE: begin
                    pkt = {ID_BASE, ID_THREE, 24'h0};
                    n   = 2;
                end
                default: begin
                    n = 0;
                end
            endcase
        end else begin
            chg          = btn ^ prev_buttons;
            prev_buttons = btn;
            send = chg[0] || chg[2] || (chg[1] && active_proto != PROTO_TWO) ||
                   it.dx != 16'h0 || it.dy != 16'h0 ||
                   (active_proto == PROTO_WHEEL && it.wheel != 8'h0);
            if (send) begin
                x = scale_clip(it.dx, x_gain);
                y = scale_clip(it.dy, y_gain);
                if (active_proto == PROTO_FIVE) begin
                    // Buttons are active low here and the y axis points the other way.
                    xl     = scale_clip(it.dx_late, x_gain);
                    yl     = scale_clip(it.dy_late, y_gain);
                    b0     = SYNC_8BIT | {5'b00000, ~l, ~m, ~r};
                    pkt    = {b0, x, 8'(8'd0 - y), xl, 8'(8'd0 - yl)};
                    n      = 5;
                    frame8 = 1'b1;
                end else begin
                    b0 = SYNC_7BIT | {4'b0000, y[7:6], x[7:6]};
                    if (r) begin
                        b0 = b0 | RIGHT_BIT;
                    end
                    if (l) begin
                        b0 = b0 | LEFT_BIT;
                    end
                    pkt[39:16] = {b0, x & LOW6_MASK, y & LOW6_MASK};
                    n          = 3;
                    if (active_proto == PROTO_WHEEL) begin
                        if ($signed(it.wheel) > $signed(WHEEL_LIMIT)) begin
                            w = WHEEL_LIMIT;
                        end else if ($signed(it.wheel) < -$signed(WHEEL_LIMIT)) begin
                            w = 8'(8'd0 - WHEEL_LIMIT);
                        end else begin
                            w = it.wheel;
                        end
                        b3 = 8'(8'd0 - w) & WHEEL_MASK;
                        if (m) begin
                            b3 = b3 | WHEEL_MID;
                        end
                        pkt[15:8] = b3;
                        n         = 4;
                    end else if (active_proto == PROTO_THREE && (m || chg[1])) begin
                        // The fourth byte only goes out when the middle button matters.
                        pkt[15:8] = m ? THREE_MID : 8'h00;
                        n         = 4;
                    end
                end
            end
        end
        return n;
    endfunction

    // Mostly zero or small motion so that reports both skip and scale visibly, with
    // full-range values and the extremes mixed in.
    function automatic logic [15:0] random_motion();
        int unsigned pick;
        int          span;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 300);
        if (pick < 25) begin
            return 16'h0000;
        end else if (pick < 70) begin
            return ($urandom_range(0, 1) != 0) ? 16'(-span) : 16'(span);
        end else if (pick < 90) begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // Reports keep their buttons most of the time so that motion and wheel decide
    // whether a packet goes out; identify requests favor the selecting patterns.
    function automatic mouse_item_t random_item();
        mouse_item_t it;
        logic [2:0]  btn;
        it.kind    = ($urandom_range(0, 99) < 12) ? KIND_IDENTIFY : KIND_REPORT;
        it.dx      = random_motion();
        it.dy      = random_motion();
        it.dx_late = random_motion();
        it.dy_late = random_motion();
        it.wheel   = ($urandom_range(0, 99) < 40) ? 8'h00 : 8'($urandom);
        it.revert  = 1'($urandom_range(0, 1));
        if (it.kind == KIND_IDENTIFY) begin
            case ($urandom_range(0, 5))
                0:       btn = 3'b000;
                1:       btn = 3'b001;
                2:       btn = 3'b100;
                3:       btn = 3'b010;
                4:       btn = 3'b101;
                default: btn = 3'($urandom);
            endcase
        end else begin
            btn = ($urandom_range(0, 99) < 65) ? held_buttons : 3'($urandom);
            held_buttons = btn;
        end
        {it.right, it.middle, it.left} = btn;
        return it;
    endfunction

    // Offers one transaction, waits for it to be taken and records the bytes it owes.
    task automatic send_item(input mouse_item_t it, input logic typed, input logic [2:0] n_typed,
                             input logic [PACKET_W-1:0] typed_bytes, input logic typed_frame);
        logic [PACKET_W-1:0] pkt;
        logic                frame8;
        int                  n;
        serial_byte_t        entry;
        @(negedge clk);
        mouse_in.valid           <= 1'b1;
        mouse_in.kind            <= it.kind;
        mouse_in.dx              <= it.dx;
        mouse_in.dy              <= it.dy;
        mouse_in.dx_late         <= it.dx_late;
        mouse_in.dy_late         <= it.dy_late;
        mouse_in.wheel_delta     <= it.wheel;
        mouse_in.left_down       <= it.left;
        mouse_in.middle_down     <= it.middle;
        mouse_in.right_down      <= it.right;
        mouse_in.revert_protocol <= it.revert;
        do begin
            @(posedge clk);
        end while (!mouse_in.ready);
        // The state copy moves on even when the row's bytes were typed in.
        n = encode_item(it, pkt, frame8);
        if (typed) begin
            n      = n_typed;
            pkt    = typed_bytes;
            frame8 = typed_frame;
        end
        for (int i = 0; i < n; i++) begin
            entry.data  = pkt[PACKET_W-1-8*i -: 8];
            entry.last  = (i == n - 1);
            entry.eight = frame8;
            pending_bytes.push_back(entry);
        end
    endtask

    task automatic pause_input(input int cycles);
        repeat (cycles) @(negedge clk) mouse_in.valid <= 1'b0;
    endtask

    // Lets every owed byte come out, then gives a report that sends nothing time to
    // leave the pipeline as well, so that the encoder is truly idle afterwards.
    task automatic wait_drained();
        @(negedge clk);
        mouse_in.valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            CFG_DEFAULT_PROTOCOL: default_proto = t_proto'(data[1:0]);
            CFG_SWAP_BUTTONS:     swap_on       = data[0];
            CFG_GAIN_ENABLE:      gain_on       = data[0];
            CFG_X_GAIN:           x_gain        = data;
            CFG_Y_GAIN:           y_gain        = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_proto dp, input logic sw, input logic ge,
                                  input logic [15:0] xg, input logic [15:0] yg);
        write_register(CFG_DEFAULT_PROTOCOL, 16'(dp));
        write_register(CFG_SWAP_BUTTONS, 16'(sw));
        write_register(CFG_GAIN_ENABLE, 16'(ge));
        write_register(CFG_X_GAIN, xg);
        write_register(CFG_Y_GAIN, yg);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Every byte handed over is compared with the oldest one still owed.
    always @(posedge clk) begin
        serial_byte_t want;
        if (rst_n && serial_out.valid && serial_out.ready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: byte %h last %b frame8 %b arrived with nothing owed",
                         $time, serial_out.tx_byte, serial_out.last, serial_out.eight_bit_frame);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (serial_out.tx_byte !== want.data || serial_out.last !== want.last ||
                    serial_out.eight_bit_frame !== want.eight) begin
                    $display("%0t: expected byte %h last %b frame8 %b, got byte %h last %b frame8 %b",
                             $time, want.data, want.last, want.eight, serial_out.tx_byte,
                             serial_out.last, serial_out.eight_bit_frame);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: the slowest correct run needs only a small part of this.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver. It switches between stretches of different readiness, from always
    // ready down to rarely ready, and on request holds off entirely for a long
    // stretch so that the pipeline fills and the input side stalls.
    initial begin : receiver
        int hold_left;
        int pattern_left;
        int ready_pct;
        int stall_served;
        hold_left        = 0;
        pattern_left     = 0;
        ready_pct        = 100;
        stall_served     = 0;
        serial_out.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_served != stall_requests) begin
                stall_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                serial_out.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(20, 80);
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                end
                pattern_left--;
                serial_out.ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // Sender and sequencing of the whole run.
    initial begin : sender
        stimulus_row_t row;
        mouse_item_t   it;
        int            burst_left;

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        mouse_in.valid           = 1'b0;
        mouse_in.kind            = KIND_REPORT;
        mouse_in.dx              = '0;
        mouse_in.dy              = '0;
        mouse_in.dx_late         = '0;
        mouse_in.dy_late         = '0;
        mouse_in.wheel_delta     = '0;
        mouse_in.left_down       = 1'b0;
        mouse_in.middle_down     = 1'b0;
        mouse_in.right_down      = 1'b0;
        mouse_in.revert_protocol = 1'b0;

        // The copies start from the values the encoder takes at reset.
        default_proto = PROTO_TWO;
        swap_on       = 1'b0;
        gain_on       = 1'b0;
        x_gain        = GAIN_RESET;
        y_gain        = GAIN_RESET;
        active_proto  = PROTO_TWO;
        prev_buttons  = 3'b000;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows, with the odd short gap between them.
        for (int i = 0; i < $size(DIRECTED_TABLE); i++) begin
            row        = DIRECTED_TABLE[i];
            it.kind    = row.kind;
            it.dx      = row.dx;
            it.dy      = row.dy;
            it.dx_late = row.dx_late;
            it.dy_late = row.dy_late;
            it.wheel   = row.wheel;
            it.left    = row.left;
            it.middle  = row.middle;
            it.right   = row.right;
            it.revert  = row.revert;
            send_item(it, row.typed, row.n_bytes, row.bytes, row.frame8);
            if ($urandom_range(0, 3) == 0) begin
                pause_input($urandom_range(1, 3));
            end
        end
        wait_drained();

        // Random phases. Each starts from an idle encoder with all registers rewritten:
        // first the extremes (zero and full-scale gain, the five-byte default), then a
        // halving gain that exercises the rounding, then gain off with arbitrary gain
        // values that must be ignored, and last modest random gains.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       apply_settings(PROTO_FIVE, 1'b1, 1'b1, 16'h0000, 16'hFFFF);
                1:       apply_settings(PROTO_WHEEL, 1'b0, 1'b1, 16'd256, 16'd128);
                2:       apply_settings(PROTO_THREE, 1'b1, 1'b0, 16'($urandom), 16'($urandom));
                default: apply_settings(PROTO_TWO, 1'b0, 1'b1, 16'($urandom_range(0, 1023)),
                                        16'($urandom_range(0, 1023)));
            endcase
            burst_left = 0;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                // The receiver holds off while the sender keeps offering transactions.
                if ((phase == 0 && k == 10) || (phase == 3 && k == 25)) begin
                    stall_requests++;
                end
                // Here the sender waits until every owed byte has come out.
                if (phase == 1 && k == 20) begin
                    wait_drained();
                end
                if (burst_left == 0) begin
                    pause_input($urandom_range(0, 6));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                send_item(random_item(), PREDICTED, 3'd0, '0, 1'b0);
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
